>>> design/rdp_pkg.sv
`default_nettype none

package rdp_pkg;

  localparam int unsigned CODE_W  = 8;
  localparam int unsigned YEAR_W  = 15;
  localparam int unsigned QUOT_W  = 9;
  localparam int unsigned MDAY_W  = 9;
  localparam int unsigned TOD_W   = 17;
  localparam int unsigned DAYS_W  = 22;
  localparam int unsigned SECS_W  = 38;

  localparam int unsigned SECS_PER_DAY = 86400;
  localparam int unsigned EPOCH_YEAR   = 1970;
  localparam int unsigned MAX_YEAR     = 9999;

  // whole days from year 1 through 1969
  localparam int unsigned DAYS_TO_EPOCH =
    (EPOCH_YEAR - 1) * 365 + (EPOCH_YEAR - 1) / 4 - (EPOCH_YEAR - 1) / 100 +
    (EPOCH_YEAR - 1) / 400;

  // floor(y / 100) as (y * RECIP_100) >> RECIP_SHIFT, exact for y below 10000
  localparam int unsigned RECIP_100   = 5243;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam int unsigned RECIP_W     = 13;
  localparam int unsigned PROD_W      = YEAR_W + RECIP_W;

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [YEAR_W-1:0] year_t;
  typedef logic [QUOT_W-1:0] quot_t;
  typedef logic [MDAY_W-1:0] mday_t;
  typedef logic [TOD_W-1:0]  tod_t;
  typedef logic [DAYS_W-1:0] days_t;
  typedef logic [SECS_W-1:0] secs_t;

  function automatic mday_t days_before_month(input logic [3:0] month_idx);
    mday_t d;
    unique case (month_idx)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // packed bcd: high nibble times ten plus low nibble, no digit check
  function automatic code_t decode_byte(input code_t raw, input logic bin);
    code_t hi;
    code_t lo;
    hi = {4'd0, raw[7:4]};
    lo = {4'd0, raw[3:0]};
    if (bin) begin
      return raw;
    end
    return (hi << 3) + (hi << 1) + lo;
  endfunction

endpackage

`default_nettype wire

>>> design/rdp_in_if.sv
`default_nettype none

interface rdp_in_if;
  import rdp_pkg::*;

  logic  valid;
  logic  ready;
  code_t second_code;
  code_t minute_code;
  code_t hour_code;
  code_t day_code;
  code_t month_code;
  code_t year_code;
  code_t century_code;

  modport source (
    output valid, second_code, minute_code, hour_code, day_code, month_code,
           year_code, century_code,
    input  ready
  );

  modport sink (
    input  valid, second_code, minute_code, hour_code, day_code, month_code,
           year_code, century_code,
    output ready
  );
endinterface

`default_nettype wire

>>> design/rdp_out_if.sv
`default_nettype none

interface rdp_out_if;
  import rdp_pkg::*;

  logic  valid;
  logic  ready;
  secs_t posix_seconds;
  logic  date_valid;

  modport source (
    output valid, posix_seconds, date_valid,
    input  ready
  );

  modport sink (
    input  valid, posix_seconds, date_valid,
    output ready
  );
endinterface

`default_nettype wire

>>> design/rtc_date_to_posix_seconds_core.sv
`default_nettype none

// Converts the seven raw clock-register bytes (seconds, minutes, hours,
// day, month, year, century) into seconds since 1970-01-01 00:00:00 under
// the Gregorian leap rule. Bytes are packed BCD unless cfg_wdata wrote
// binary mode; change the mode only while no request is in flight. Dates
// with a bad month, day, hour, minute or second, or a year outside
// 1970..9999, come out as zero with date_valid low. The block is a
// five-stage pipeline: a request can enter every cycle unless all stages
// are full and the output is stalled; each stage stalls only when the stage
// after it is full and stalled, so a waiting result does not block new
// requests while there is room. The year-to-days path (two reciprocal
// multiplies, then the day-count sum) and the final days*86400 multiply
// sit in their own stages.
module rtc_date_to_posix_seconds_core (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata,
  rdp_in_if.sink    in_chan,
  rdp_out_if.source out_chan
);
  import rdp_pkg::*;

  // configuration
  logic binary_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      binary_mode_r <= 1'b0;
    end else if (cfg_we) begin
      binary_mode_r <= cfg_wdata;
    end
  end

  // stage valid bits and per-stage advance enables
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5;

  assign en5 = !v5_r || out_chan.ready;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  // no request is taken while reset is held
  assign in_chan.ready = en1 && rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= in_chan.valid;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
      if (en4) begin
        v4_r <= v3_r;
      end
      if (en5) begin
        v5_r <= v4_r;
      end
    end
  end

  // ---------------------------------------------------------------
  // stage 1: decode every byte from bcd or binary
  // ---------------------------------------------------------------
  code_t sec1_r, min1_r, hour1_r, day1_r, mon1_r, yy1_r, cen1_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      sec1_r  <= decode_byte(in_chan.second_code,  binary_mode_r);
      min1_r  <= decode_byte(in_chan.minute_code,  binary_mode_r);
      hour1_r <= decode_byte(in_chan.hour_code,    binary_mode_r);
      day1_r  <= decode_byte(in_chan.day_code,     binary_mode_r);
      mon1_r  <= decode_byte(in_chan.month_code,   binary_mode_r);
      yy1_r   <= decode_byte(in_chan.year_code,    binary_mode_r);
      cen1_r  <= decode_byte(in_chan.century_code, binary_mode_r);
    end
  end

  // ---------------------------------------------------------------
  // stage 2: full year, field range checks, time of day, day in year
  // ---------------------------------------------------------------
  year_t year2_nxt;
  logic  fields_ok2_nxt;
  tod_t  tod2_nxt;
  mday_t mday2_nxt;
  logic  late2_nxt;

  always_comb begin
    year2_nxt = YEAR_W'(cen1_r) * YEAR_W'(100) + YEAR_W'(yy1_r);
    fields_ok2_nxt = (mon1_r >= 8'd1) && (mon1_r <= 8'd12) &&
                     (day1_r >= 8'd1) && (day1_r <= 8'd31) &&
                     (hour1_r <= 8'd23) && (min1_r <= 8'd59) &&
                     (sec1_r <= 8'd59);
    // only meaningful when the fields are in range; wraps otherwise
    tod2_nxt = TOD_W'(hour1_r) * TOD_W'(3600) + TOD_W'(min1_r) * TOD_W'(60) +
               TOD_W'(sec1_r);
    // day counts from zero within the year
    mday2_nxt = days_before_month(mon1_r[3:0] - 4'd1) + MDAY_W'(day1_r) -
                MDAY_W'(1);
    // leap day only counts after february
    late2_nxt = (mon1_r > 8'd2);
  end

  year_t year2_r;
  logic  fields_ok2_r;
  tod_t  tod2_r;
  mday_t mday2_r;
  logic  late2_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      year2_r      <= year2_nxt;
      fields_ok2_r <= fields_ok2_nxt;
      tod2_r       <= tod2_nxt;
      mday2_r      <= mday2_nxt;
      late2_r      <= late2_nxt;
    end
  end

  // ---------------------------------------------------------------
  // stage 3: divide year and year-1 by 100 via reciprocal multiply
  // ---------------------------------------------------------------
  logic [PROD_W-1:0] prod_y3, prod_p3;
  quot_t q_year3_nxt, q_prev3_nxt;
  logic  year_ok3_nxt;

  always_comb begin
    prod_y3 = PROD_W'(year2_r) * PROD_W'(RECIP_100);
    prod_p3 = PROD_W'(year2_r - YEAR_W'(1)) * PROD_W'(RECIP_100);
    q_year3_nxt = prod_y3[RECIP_SHIFT +: QUOT_W];
    q_prev3_nxt = prod_p3[RECIP_SHIFT +: QUOT_W];
    year_ok3_nxt = (year2_r >= YEAR_W'(EPOCH_YEAR)) &&
                   (year2_r <= YEAR_W'(MAX_YEAR));
  end

  year_t year3_r;
  quot_t q_year3_r, q_prev3_r;
  logic  ok3_r;
  tod_t  tod3_r;
  mday_t mday3_r;
  logic  late3_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      year3_r   <= year2_r;
      q_year3_r <= q_year3_nxt;
      q_prev3_r <= q_prev3_nxt;
      ok3_r     <= fields_ok2_r && year_ok3_nxt;
      tod3_r    <= tod2_r;
      mday3_r   <= mday2_r;
      late3_r   <= late2_r;
    end
  end

  // ---------------------------------------------------------------
  // stage 4: leap test and day count since the epoch
  // ---------------------------------------------------------------
  year_t prev4;
  year_t rem100_4;
  logic  leap4;
  days_t days4_nxt;

  always_comb begin
    prev4 = year3_r - YEAR_W'(1);
    rem100_4 = year3_r - YEAR_W'(q_year3_r) * YEAR_W'(100);
    // divisible by 400 is a century whose quotient is a multiple of four
    leap4 = (year3_r[1:0] == 2'd0) &&
            ((rem100_4 != '0) || (q_year3_r[1:0] == 2'd0));
    days4_nxt = DAYS_W'(prev4) * DAYS_W'(365) + DAYS_W'(prev4 >> 2) -
                DAYS_W'(q_prev3_r) + DAYS_W'(q_prev3_r >> 2) -
                DAYS_W'(DAYS_TO_EPOCH) + DAYS_W'(mday3_r) +
                DAYS_W'(late3_r && leap4);
  end

  days_t days4_r;
  logic  ok4_r;
  tod_t  tod4_r;

  always_ff @(posedge clk) begin
    if (en4) begin
      days4_r <= days4_nxt;
      ok4_r   <= ok3_r;
      tod4_r  <= tod3_r;
    end
  end

  // ---------------------------------------------------------------
  // stage 5: scale days to seconds, add time of day, zero if invalid
  // ---------------------------------------------------------------
  secs_t secs5_nxt;

  always_comb begin
    secs5_nxt = SECS_W'(days4_r) * SECS_W'(SECS_PER_DAY) + SECS_W'(tod4_r);
    if (!ok4_r) begin
      secs5_nxt = '0;
    end
  end

  secs_t secs5_r;
  logic  ok5_r;

  always_ff @(posedge clk) begin
    if (en5) begin
      secs5_r <= secs5_nxt;
      ok5_r   <= ok4_r;
    end
  end

  assign out_chan.valid         = v5_r;
  assign out_chan.posix_seconds = secs5_r;
  assign out_chan.date_valid    = ok5_r;

endmodule

`default_nettype wire

>>> dv/rtc_date_to_posix_seconds_core_tb.sv
`default_nettype none

module rtc_date_to_posix_seconds_core_tb;
  import rdp_pkg::*;

  // raw clock-register bytes of one request
  typedef struct packed {
    code_t sec;
    code_t min;
    code_t hour;
    code_t day;
    code_t month;
    code_t year;
    code_t century;
  } rtc_regs_t;

  // converted time as the block should return it
  typedef struct packed {
    secs_t secs;
    logic  ok;
  } posix_t;

  localparam int unsigned STALL_LIMIT  = 4000;  // cycles with nothing accepted
  localparam int unsigned DRAIN_CYCLES = 12;    // five-stage pipe plus margin
  localparam int unsigned RAND_PHASES  = 8;
  localparam int unsigned PHASE_ITEMS  = 125;
  localparam int unsigned MAX_PRINTS   = 40;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  rdp_in_if  in_chan ();
  rdp_out_if out_chan ();

  rtc_date_to_posix_seconds_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  rtc_regs_t   rtc_reg_q[$];  // requests not yet taken by the block
  posix_t      posix_q[$];    // predicted results, oldest first
  logic        bin_mode;      // our copy of the binary-mode register
  logic        in_taken;      // request accepted at the last rising edge
  int unsigned err_count;
  int unsigned idle_cycles;

  // sender burst state and receiver stall pattern
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned stall_mode;
  int unsigned stall_left;
  logic [7:0]  stall_pat;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic flag_mismatch(input string msg);
    if (err_count < MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    err_count++;
  endtask

  // one register byte as the block reads it: packed bcd unless binary mode
  function automatic int unsigned reg_value(input code_t raw, input logic bin);
    if (bin) begin
      return raw;
    end
    return raw[7:4] * 10 + raw[3:0];
  endfunction

  // full conversion of one register set to seconds since the epoch
  function automatic posix_t date_to_posix(input rtc_regs_t r, input logic bin);
    int unsigned s;
    int unsigned mi;
    int unsigned h;
    int unsigned d;
    int unsigned mo;
    int unsigned y;
    int unsigned yp;
    int unsigned days;
    logic        leap;
    posix_t      res;
    s  = reg_value(r.sec, bin);
    mi = reg_value(r.min, bin);
    h  = reg_value(r.hour, bin);
    d  = reg_value(r.day, bin);
    mo = reg_value(r.month, bin);
    y  = reg_value(r.century, bin) * 100 + reg_value(r.year, bin);
    res.secs = '0;
    res.ok   = 1'b0;
    // bad field or year outside 1970..9999: zero with the flag low
    if (mo < 1 || mo > 12 || d < 1 || d > 31 || h > 23 || mi > 59 || s > 59 ||
        y < 1970 || y > 9999) begin
      return res;
    end
    // whole days in the years 1970 .. y-1
    yp   = y - 1;
    days = (yp * 365 + yp / 4 - yp / 100 + yp / 400) -
           (1969 * 365 + 1969 / 4 - 1969 / 100 + 1969 / 400);
    // whole months before this one, february taken as 28 days
    for (int m = 1; m < mo; m++) begin
      case (m)
        2:           days += 28;
        4, 6, 9, 11: days += 30;
        default:     days += 31;
      endcase
    end
    // leap day only once february is past; centuries leap only by 400
    leap = (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    if (mo > 2 && leap) begin
      days += 1;
    end
    // day of month counts from one, past-month-end days simply run on
    days += d - 1;
    res.secs = secs_t'(longint'(days) * 86400 + longint'(h) * 3600 +
                       longint'(mi) * 60 + longint'(s));
    res.ok   = 1'b1;
    return res;
  endfunction

  // encode a small number the way the register holds it in the given mode
  function automatic code_t to_code(input int unsigned v, input logic bin);
    if (bin) begin
      return code_t'(v);
    end
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  function automatic rtc_regs_t date_regs(input int unsigned y, input int unsigned mo,
                                          input int unsigned d, input int unsigned h,
                                          input int unsigned mi, input int unsigned s,
                                          input logic bin);
    rtc_regs_t r;
    r.sec     = to_code(s, bin);
    r.min     = to_code(mi, bin);
    r.hour    = to_code(h, bin);
    r.day     = to_code(d, bin);
    r.month   = to_code(mo, bin);
    r.year    = to_code(y % 100, bin);
    r.century = to_code(y / 100, bin);
    return r;
  endfunction

  // a well-formed date with the year leaning toward leap and range edges
  function automatic rtc_regs_t rand_date(input logic bin);
    int unsigned y;
    int unsigned mo;
    int unsigned d;
    case ($urandom_range(0, 4))
      0:       y = 1970 + $urandom_range(0, 40);
      1:       y = $urandom_range(20, 99) * 100 + $urandom_range(0, 4);
      2:       y = 9990 + $urandom_range(0, 9);
      3:       y = $urandom_range(500, 2499) * 4;
      default: y = $urandom_range(1970, 9999);
    endcase
    // lean on the february / march boundary and month ends
    mo = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 3) : $urandom_range(1, 12);
    d  = ($urandom_range(0, 2) == 0) ? $urandom_range(27, 31) : $urandom_range(1, 31);
    return date_regs(y, mo, d, $urandom_range(0, 23), $urandom_range(0, 59),
                     $urandom_range(0, 59), bin);
  endfunction

  // random content: mostly valid dates, the rest raw noise or one bad field
  function automatic rtc_regs_t rand_request(input logic bin);
    rtc_regs_t r;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    r    = rand_date(bin);
    if (pick == 8) begin
      r = rtc_regs_t'({$urandom(), $urandom()});
    end else if (pick == 9) begin
      case ($urandom_range(0, 6))
        0: r.sec     = to_code($urandom_range(60, 99), bin);
        1: r.min     = to_code($urandom_range(60, 99), bin);
        2: r.hour    = to_code($urandom_range(24, 99), bin);
        3: r.day     = ($urandom_range(0, 1) == 1) ? to_code($urandom_range(32, 99), bin)
                                                   : to_code(0, bin);
        4: r.month   = ($urandom_range(0, 1) == 1) ? to_code($urandom_range(13, 99), bin)
                                                   : to_code(0, bin);
        5: begin
          r.century = to_code($urandom_range(0, 19), bin);
          r.year    = to_code($urandom_range(0, 69), bin);
        end
        default: r.century = code_t'($urandom_range(0, 255));
      endcase
    end
    return r;
  endfunction

  // mode change only with the pipe empty and no request waiting
  task automatic write_mode(input logic bin);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= bin;
    bin_mode  = bin;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic drain;
    while (rtc_reg_q.size() != 0 || posix_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // drive side: new request data and valid change on the falling edge
  always @(negedge clk) begin
    logic      nv;
    rtc_regs_t nd;
    nv = 1'b0;
    nd = {in_chan.second_code, in_chan.minute_code, in_chan.hour_code, in_chan.day_code,
          in_chan.month_code, in_chan.year_code, in_chan.century_code};
    if (!rst_n) begin
      nv = 1'b0;
    end else if (in_chan.valid && !in_taken) begin
      // request not taken yet: hold it unchanged
      nv = 1'b1;
    end else if (gap_left != 0) begin
      gap_left--;
    end else if (rtc_reg_q.size() != 0) begin
      nv = 1'b1;
      nd = rtc_reg_q[0];
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 24);
        gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 7) : 0;
      end else begin
        burst_left--;
      end
    end
    in_chan.valid        <= nv;
    in_chan.second_code  <= nd.sec;
    in_chan.minute_code  <= nd.min;
    in_chan.hour_code    <= nd.hour;
    in_chan.day_code     <= nd.day;
    in_chan.month_code   <= nd.month;
    in_chan.year_code    <= nd.year;
    in_chan.century_code <= nd.century;
  end

  // result side: ready follows a stall pattern that changes every so often
  always @(negedge clk) begin
    logic nr;
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 4);
      stall_left = $urandom_range(30, 200);
      stall_pat  = 8'($urandom());
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       nr = 1'b1;
      1:       nr = 1'($urandom_range(0, 1));
      2:       nr = ($urandom_range(0, 4) == 0);
      3: begin
        nr        = stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[7:1]};
      end
      default: nr = ($urandom_range(0, 7) != 0);
    endcase
    out_chan.ready <= rst_n ? nr : 1'b0;
  end

  // sample side: requests and results are taken at the rising edge
  always @(posedge clk) begin
    rtc_regs_t r;
    posix_t    want;
    in_taken = 1'b0;
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) begin
        r = {in_chan.second_code, in_chan.minute_code, in_chan.hour_code,
             in_chan.day_code, in_chan.month_code, in_chan.year_code,
             in_chan.century_code};
        posix_q.push_back(date_to_posix(r, bin_mode));
        void'(rtc_reg_q.pop_front());
        in_taken = 1'b1;
      end
      if (out_chan.valid && out_chan.ready) begin
        if (posix_q.size() == 0) begin
          flag_mismatch($sformatf("result %0d/%0b with no request outstanding",
                                  out_chan.posix_seconds, out_chan.date_valid));
        end else begin
          want = posix_q.pop_front();
          if (out_chan.posix_seconds !== want.secs) begin
            flag_mismatch($sformatf("posix_seconds %0d, want %0d",
                                    out_chan.posix_seconds, want.secs));
          end
          if (out_chan.date_valid !== want.ok) begin
            flag_mismatch($sformatf("date_valid %0b, want %0b",
                                    out_chan.date_valid, want.ok));
          end
        end
      end
    end
  end

  // watchdog: too long with work outstanding and nothing moving
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (rtc_reg_q.size() == 0 && posix_q.size() == 0)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic bin;
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_wdata            = 1'b0;
    bin_mode             = 1'b0;
    in_taken             = 1'b0;
    err_count            = 0;
    idle_cycles          = 0;
    burst_left           = 1;
    gap_left             = 0;
    stall_mode           = 0;
    stall_left           = 0;
    stall_pat            = 8'hff;
    in_chan.valid        = 1'b0;
    in_chan.second_code  = '0;
    in_chan.minute_code  = '0;
    in_chan.hour_code    = '0;
    in_chan.day_code     = '0;
    in_chan.month_code   = '0;
    in_chan.year_code    = '0;
    in_chan.century_code = '0;
    out_chan.ready       = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // packed bcd corners
    write_mode(1'b0);
    rtc_reg_q.push_back(date_regs(1970, 1, 1, 0, 0, 0, 1'b0));      // the epoch itself
    rtc_reg_q.push_back(date_regs(9999, 12, 31, 23, 59, 59, 1'b0)); // last second
    rtc_reg_q.push_back(date_regs(2000, 3, 1, 12, 0, 0, 1'b0));     // leap by 400
    rtc_reg_q.push_back(date_regs(2100, 3, 1, 0, 0, 0, 1'b0));      // century, no leap
    rtc_reg_q.push_back(date_regs(2024, 2, 29, 6, 30, 15, 1'b0));   // leap day itself
    rtc_reg_q.push_back(date_regs(2023, 2, 31, 1, 2, 3, 1'b0));     // runs into march
    rtc_reg_q.push_back(date_regs(1969, 12, 31, 23, 59, 59, 1'b0)); // before the epoch
    rtc_reg_q.push_back(date_regs(2020, 13, 1, 0, 0, 0, 1'b0));     // month too high
    rtc_reg_q.push_back(date_regs(2020, 0, 1, 0, 0, 0, 1'b0));      // month zero
    rtc_reg_q.push_back(date_regs(2020, 5, 0, 0, 0, 0, 1'b0));      // day zero
    rtc_reg_q.push_back(date_regs(2020, 5, 32, 0, 0, 0, 1'b0));     // day too high
    rtc_reg_q.push_back(date_regs(2020, 5, 5, 24, 0, 0, 1'b0));     // hour too high
    rtc_reg_q.push_back(date_regs(2020, 5, 5, 0, 60, 0, 1'b0));     // minute too high
    rtc_reg_q.push_back(date_regs(2020, 5, 5, 0, 0, 60, 1'b0));     // second too high
    // digits above nine: 0x1f reads as 25, 0xa0 year pushes past 9999
    rtc_reg_q.push_back('{8'h1f, 8'h1f, 8'h1f, 8'h1f, 8'h0b, 8'h7f, 8'h1f});
    rtc_reg_q.push_back('{8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'ha0, 8'h99});
    rtc_reg_q.push_back('1);
    rtc_reg_q.push_back('0);
    drain();

    // plain binary corners
    write_mode(1'b1);
    rtc_reg_q.push_back(date_regs(1970, 1, 1, 0, 0, 0, 1'b1));
    rtc_reg_q.push_back(date_regs(9999, 12, 31, 23, 59, 59, 1'b1));
    rtc_reg_q.push_back(date_regs(2400, 3, 1, 0, 0, 1, 1'b1));
    rtc_reg_q.push_back('{8'd59, 8'd59, 8'd23, 8'd31, 8'd12, 8'd99, 8'd255}); // year too big
    rtc_reg_q.push_back('{8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd69, 8'd19});       // 1969
    rtc_reg_q.push_back('1);
    drain();

    // random phases, each with its own mode setting
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      bin = (ph < 2) ? 1'(ph) : 1'($urandom_range(0, 1));
      write_mode(bin);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        rtc_reg_q.push_back(rand_request(bin));
      end
      drain();
    end

    if (posix_q.size() != 0) begin
      flag_mismatch($sformatf("%0d results never arrived", posix_q.size()));
    end
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
design/rdp_pkg.sv
design/rdp_in_if.sv
design/rdp_out_if.sv
design/rtc_date_to_posix_seconds_core.sv
dv/rtc_date_to_posix_seconds_core_tb.sv
